/* rtl/irt_pkg.sv */
// Package for the integer to radix text converter.
// Holds radix limits, character codes, back-end state type and the digit lookup.
// No dependencies.
package irt_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int STEP_BITS      = 4;

	localparam logic [5:0] BASE_RESET   = 6'd10;
	localparam logic [5:0] BASE_MIN     = 6'd2;
	localparam logic [5:0] BASE_MAX     = 6'd36;
	localparam logic [5:0] DECIMAL_BASE = 6'd10;
	localparam logic [7:0] MINUS_CHAR   = 8'h2D;
	localparam logic [7:0] DIGIT_ZERO   = 8'h30;
	localparam logic [7:0] LETTER_BIAS  = 8'h37;

	typedef struct packed {
		logic       neg;
		logic [5:0] base;
	} irt_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_PREP,
		BK_EMIT
	} irt_state_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] dw;
		dw = {2'b00, d};
		if (d < 6'd10) begin
			return DIGIT_ZERO + dw;
		end
		return LETTER_BIAS + dw;
	endfunction

endpackage

/* rtl/irt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module irt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/irt_fifo.sv */
// Two-entry queue between the front and back ends of the converter.
// Depends on nothing.
module irt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/irt_front.sv */
// Front end: holds the radix register, accepts values and classifies them
// into magnitude, sign flag and effective radix. Depends on irt_pkg.
module irt_front
	import irt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [5:0]            cfg_data,
	input  logic                  start,
	input  logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  push,
	output logic [VALUE_BITS-1:0] mag,
	output irt_ctl_t              ctl
);

	logic [5:0] base_q;
	logic [5:0] base_eff;
	logic       neg;

	assign cfg_ready = 1'b1;
	assign push      = start && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	always_comb begin
		if (base_q < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (base_q > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = base_q;
		end
		neg = (base_eff == DECIMAL_BASE) && value[VALUE_BITS-1];
		mag = neg ? (~value + VALUE_BITS'(1)) : value;
		ctl.neg  = neg;
		ctl.base = base_eff;
	end

endmodule

/* rtl/irt_back.sv */
// Back end: divides the magnitude by the radix STEP_BITS bits at a time, stacks
// the digits in a RAM and plays them out most significant first, after a minus
// sign for negative values. Depends on irt_pkg and irt_ram.
module irt_back
	import irt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [VALUE_BITS-1:0] mag,
	input  irt_ctl_t              ctl,
	output logic                  pop,
	output logic                  strobe,
	output logic [7:0]            character,
	output logic                  last_char
);

	localparam int STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W  = STEPS * STEP_BITS;
	localparam int STEP_W = $clog2(STEPS);
	localparam int AW     = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	irt_state_t        state_q;
	irt_state_t        state_d;
	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dvd_d;
	logic [5:0]        rem_q;
	logic [5:0]        rem_d;
	logic [5:0]        base_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     ptr_q;
	logic              div_last;
	logic              ram_we;
	logic [AW-1:0]     raddr;
	logic [5:0]        rdata;
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

	assign div_last = (step_q == STEP_W'(STEPS - 1));
	assign pop      = (state_q == BK_IDLE) && !empty;
	assign ram_we   = (state_q == BK_DIV) && div_last;
	assign raddr    = (state_q == BK_PREP) ? ptr_q : ptr_q - AW'(1);

	always_comb begin
		logic [6:0]           t;
		logic [5:0]           r;
		logic [STEP_BITS-1:0] q;
		r = rem_q;
		q = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, dvd_q[DIV_W-1-i]};
			if (t >= {1'b0, base_q}) begin
				r = 6'(t - {1'b0, base_q});
				q[STEP_BITS-1-i] = 1'b1;
			end else begin
				r = t[5:0];
			end
		end
		rem_d = r;
		dvd_d = {dvd_q[DIV_W-STEP_BITS-1:0], q};
	end

	irt_ram #(
		.WIDTH(6),
		.DEPTH(VALUE_BITS)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rem_d),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_last && dvd_d == '0) begin
					state_d = BK_PREP;
				end
			end
			BK_PREP: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (ptr_q == '0) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
				end
				BK_DIV: begin
					if (div_last) begin
						step_q <= '0;
						cnt_q  <= cnt_q + CNT_W'(1);
						ptr_q  <= cnt_q[AW-1:0];
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				BK_PREP: begin
					strobe_q <= neg_q;
				end
				BK_EMIT: begin
					strobe_q <= 1'b1;
					ptr_q    <= ptr_q - AW'(1);
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				dvd_q  <= DIV_W'(mag);
				rem_q  <= '0;
				base_q <= ctl.base;
				neg_q  <= ctl.neg;
			end
			BK_DIV: begin
				dvd_q <= dvd_d;
				rem_q <= div_last ? 6'd0 : rem_d;
			end
			BK_PREP: begin
				char_q <= MINUS_CHAR;
				last_q <= 1'b0;
			end
			BK_EMIT: begin
				char_q <= digit_char(rdata);
				last_q <= (ptr_q == '0);
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

endmodule

/* rtl/integer_to_radix_text.sv */
// Integer to radix text converter: emits the text of one value, one character per beat.
// Each digit is worked out in the shared 4-bit-per-cycle divider, then characters leave one
// per cycle. The back end takes a new value only once it has finished the last character of
// the previous one; a two-entry queue takes new values while the divider works.
// Results cannot be stalled. Reset sets the radix to ten. Uses irt_pkg.
module integer_to_radix_text
	import irt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [5:0]                   cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         strobe,
	output logic [7:0]                   character,
	output logic                         last_char
);

	localparam int ENTRY_W = VALUE_BITS + $bits(irt_ctl_t);

	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;
	logic [VALUE_BITS-1:0] front_mag;
	irt_ctl_t              front_ctl;
	logic [ENTRY_W-1:0]    q_data;
	logic [VALUE_BITS-1:0] back_mag;
	irt_ctl_t              back_ctl;

	assign busy = full;
	assign {back_mag, back_ctl} = q_data;

	irt_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.start    (start),
		.full     (full),
		.value    (value),
		.push     (push),
		.mag      (front_mag),
		.ctl      (front_ctl)
	);

	irt_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({front_mag, front_ctl}),
		.pop      (pop),
		.pop_data (q_data),
		.full     (full),
		.empty    (empty)
	);

	irt_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.mag      (back_mag),
		.ctl      (back_ctl),
		.pop      (pop),
		.strobe   (strobe),
		.character(character),
		.last_char(last_char)
	);

endmodule
